// File: sv/afbu_pkg.sv
// Package for the activation forward/backward unit: widths, codes, the request,
// response and pipeline stage types, and the shared saturating clamp.
// No dependencies; every other file of the unit refers to it by scoped names.
package afbu_pkg;

  // Number format of the data fields and of the slope register.
  localparam int DATA_WIDTH     = 16;
  localparam int FRAC_BITS      = 12;
  localparam int SLOPE_FRAC     = 12;
  localparam int SLOPE_WIDTH    = 13;
  localparam int KIND_WIDTH     = 2;
  localparam int CFG_ADDR_WIDTH = 2;
  localparam int CFG_DATA_WIDTH = SLOPE_WIDTH;
  localparam int SLOPE_RESET    = 41;

  // Internal widths: multiplier operands, products, the final sum and the
  // piecewise-linear datapath.
  localparam int OPND_W = ((DATA_WIDTH > SLOPE_WIDTH) ? DATA_WIDTH : SLOPE_WIDTH) + 2;
  localparam int PROD_W = 2 * OPND_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int PWL_W  = ((DATA_WIDTH + 2) > (FRAC_BITS + 4)) ?
                          (DATA_WIDTH + 2) : (FRAC_BITS + 4);

  localparam logic signed [SUM_W-1:0] SUM_MAX =
    {{(SUM_W - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN =
    {{(SUM_W - DATA_WIDTH + 1){1'b1}}, {(DATA_WIDTH - 1){1'b0}}};

  typedef enum logic [KIND_WIDTH-1:0] {
    KIND_LEAKY   = 2'd0,
    KIND_SIGMOID = 2'd1,
    KIND_TANH    = 2'd2
  } act_kind_e;

  typedef enum logic {
    PASS_FORWARD  = 1'b0,
    PASS_BACKWARD = 1'b1
  } act_pass_e;

  typedef enum logic [CFG_ADDR_WIDTH-1:0] {
    REG_KIND  = 2'd0,
    REG_DIR   = 2'd1,
    REG_SLOPE = 2'd2
  } cfg_reg_e;

  // Operation carried down the pipeline, decoded once at entry.
  typedef enum logic [2:0] {
    OP_FWD_LEAKY = 3'd0,
    OP_FWD_SIG   = 3'd1,
    OP_FWD_TANH  = 3'd2,
    OP_BWD_LEAKY = 3'd3,
    OP_BWD_SIG   = 3'd4,
    OP_BWD_TANH  = 3'd5
  } act_op_e;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] x_value;
    logic signed [DATA_WIDTH-1:0] y_value;
    logic signed [DATA_WIDTH-1:0] upstream_grad;
    logic signed [DATA_WIDTH-1:0] grad_sum;
  } act_req_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] result_value;
    logic                         saturated;
  } act_rsp_t;

  // Entry register contents.
  typedef struct packed {
    act_op_e                 op;
    act_req_t                req;
    logic [SLOPE_WIDTH-1:0]  slope;
  } afbu_s0_t;

  // After the first multiplier.
  typedef struct packed {
    act_op_e                      op;
    logic                         x_pos;
    logic signed [DATA_WIDTH-1:0] x;
    logic signed [DATA_WIDTH-1:0] g;
    logic signed [DATA_WIDTH-1:0] acc;
    logic signed [PWL_W-1:0]      pwl;
    logic signed [PROD_W-1:0]     m1;
  } afbu_s1_t;

  // After the derivative stage.
  typedef struct packed {
    act_op_e                      op;
    logic signed [DATA_WIDTH-1:0] base;
    logic signed [PROD_W-1:0]     addend;
    logic signed [DATA_WIDTH-1:0] d;
    logic signed [DATA_WIDTH-1:0] g;
  } afbu_s2_t;

  // After the second multiplier.
  typedef struct packed {
    act_op_e                      op;
    logic signed [DATA_WIDTH-1:0] base;
    logic signed [PROD_W-1:0]     addend;
    logic signed [PROD_W-1:0]     m2;
  } afbu_s3_t;

  // Clamp a wide signed value to the data range and report the clamp.
  function automatic act_rsp_t sat_clamp(input logic signed [SUM_W-1:0] v);
    act_rsp_t r;
    r.result_value = v[DATA_WIDTH-1:0];
    r.saturated    = 1'b0;
    if (v > SUM_MAX) begin
      r.result_value = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
      r.saturated    = 1'b1;
    end else if (v < SUM_MIN) begin
      r.result_value = {1'b1, {(DATA_WIDTH - 1){1'b0}}};
      r.saturated    = 1'b1;
    end
    return r;
  endfunction

endpackage

// File: sv/afbu_front.sv
// First pipeline stage: operand selection for the first multiplier and the
// piecewise-linear sigmoid/tanh evaluation. Depends on afbu_pkg.
module afbu_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  afbu_pkg::afbu_s0_t s0_i,
  output logic               valid_o,
  output afbu_pkg::afbu_s1_t s1_o
);

  localparam int OW = afbu_pkg::OPND_W;
  localparam int PW = afbu_pkg::PWL_W;
  localparam int FB = afbu_pkg::FRAC_BITS;

  localparam logic signed [PW-1:0] ONE_P  = PW'(2 ** FB);
  localparam logic signed [PW-1:0] HALF_P = PW'((2 ** FB) / 2);
  localparam logic signed [PW-1:0] FIVE_P = PW'(5 * (2 ** FB));
  localparam logic signed [PW-1:0] SEG_P  = PW'((19 * (2 ** FB)) / 8);
  localparam logic signed [PW-1:0] K27_P  = PW'((27 * (2 ** FB)) / 32);
  localparam logic signed [PW-1:0] K5_P   = PW'((5 * (2 ** FB)) / 8);
  localparam logic signed [OW-1:0] ONE_O  = OW'(2 ** FB);

  logic signed [OW-1:0] opa, opb, slope_s;
  logic signed [PW-1:0] v, a, s, sv, pwl;
  logic                 valid_q;
  afbu_pkg::afbu_s1_t   s1_d, s1_q;

  always_comb begin
    slope_s = $signed({{(OW - afbu_pkg::SLOPE_WIDTH){1'b0}}, s0_i.slope});

    // Tanh is evaluated as 2*sigmoid(2x) - 1 on the same segments.
    if (s0_i.op == afbu_pkg::OP_FWD_TANH) begin
      v = PW'(s0_i.req.x_value) <<< 1;
    end else begin
      v = PW'(s0_i.req.x_value);
    end
    a = v[PW-1] ? -v : v;

    if (a >= FIVE_P) begin
      s = ONE_P;
    end else if (a >= SEG_P) begin
      s = (a >>> 5) + K27_P;
    end else if (a >= ONE_P) begin
      s = (a >>> 3) + K5_P;
    end else begin
      s = (a >>> 2) + HALF_P;
    end
    sv  = v[PW-1] ? (ONE_P - s) : s;
    pwl = (s0_i.op == afbu_pkg::OP_FWD_TANH) ? ((sv <<< 1) - ONE_P) : sv;

    opa = '0;
    opb = '0;
    case (s0_i.op) inside
      afbu_pkg::OP_FWD_LEAKY: begin
        opa = OW'(s0_i.req.x_value);
        opb = slope_s;
      end
      afbu_pkg::OP_BWD_LEAKY: begin
        opa = OW'(s0_i.req.upstream_grad);
        opb = slope_s;
      end
      afbu_pkg::OP_BWD_SIG: begin
        opa = OW'(s0_i.req.y_value);
        opb = ONE_O - OW'(s0_i.req.y_value);
      end
      afbu_pkg::OP_BWD_TANH: begin
        opa = OW'(s0_i.req.y_value);
        opb = OW'(s0_i.req.y_value);
      end
      default: begin
      end
    endcase

    s1_d.op    = s0_i.op;
    s1_d.x_pos = (s0_i.req.x_value > 0);
    s1_d.x     = s0_i.req.x_value;
    s1_d.g     = s0_i.req.upstream_grad;
    s1_d.acc   = s0_i.req.grad_sum;
    s1_d.pwl   = pwl;
    s1_d.m1    = opa * opb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      s1_q <= s1_d;
    end
  end

  assign valid_o = valid_q;
  assign s1_o    = s1_q;

endmodule

// File: sv/afbu_deriv.sv
// Second pipeline stage: scales the first product, forms the clamped local
// derivative and the leaky ReLU and forward terms. Depends on afbu_pkg.
module afbu_deriv (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  afbu_pkg::afbu_s1_t s1_i,
  output logic               valid_o,
  output afbu_pkg::afbu_s2_t s2_o
);

  localparam int RW = afbu_pkg::PROD_W;
  localparam logic signed [RW-1:0] ONE_W = RW'(2 ** afbu_pkg::FRAC_BITS);

  logic signed [RW-1:0] sh_slope, sh_frac, dw;
  afbu_pkg::act_rsp_t   dc;
  logic                 valid_q;
  afbu_pkg::afbu_s2_t   s2_d, s2_q;

  always_comb begin
    sh_slope = s1_i.m1 >>> afbu_pkg::SLOPE_FRAC;
    sh_frac  = s1_i.m1 >>> afbu_pkg::FRAC_BITS;
    dw       = (s1_i.op == afbu_pkg::OP_BWD_TANH) ? (ONE_W - sh_frac) : sh_frac;
    // The derivative is held at data width, so out-of-range y clamps here.
    dc       = afbu_pkg::sat_clamp(afbu_pkg::SUM_W'(dw));

    s2_d.op     = s1_i.op;
    s2_d.base   = '0;
    s2_d.addend = '0;
    s2_d.d      = dc.result_value;
    s2_d.g      = s1_i.g;
    case (s1_i.op) inside
      afbu_pkg::OP_FWD_LEAKY: begin
        s2_d.addend = s1_i.x_pos ? RW'(s1_i.x) : sh_slope;
      end
      afbu_pkg::OP_BWD_LEAKY: begin
        s2_d.base   = s1_i.acc;
        s2_d.addend = s1_i.x_pos ? RW'(s1_i.g) : sh_slope;
      end
      afbu_pkg::OP_FWD_SIG, afbu_pkg::OP_FWD_TANH: begin
        s2_d.addend = RW'(s1_i.pwl);
      end
      afbu_pkg::OP_BWD_SIG, afbu_pkg::OP_BWD_TANH: begin
        s2_d.base = s1_i.acc;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      s2_q <= s2_d;
    end
  end

  assign valid_o = valid_q;
  assign s2_o    = s2_q;

endmodule

// File: sv/afbu_mul2.sv
// Third pipeline stage: multiplies the upstream gradient by the local
// derivative for the sigmoid and tanh backward pass. Depends on afbu_pkg.
module afbu_mul2 (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  afbu_pkg::afbu_s2_t s2_i,
  output logic               valid_o,
  output afbu_pkg::afbu_s3_t s3_o
);

  logic               valid_q;
  afbu_pkg::afbu_s3_t s3_d, s3_q;

  always_comb begin
    s3_d.op     = s2_i.op;
    s3_d.base   = s2_i.base;
    s3_d.addend = s2_i.addend;
    s3_d.m2     = s2_i.g * s2_i.d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      s3_q <= s3_d;
    end
  end

  assign valid_o = valid_q;
  assign s3_o    = s3_q;

endmodule

// File: sv/afbu_accum.sv
// Last pipeline stage: adds the term to the base, saturates to the data
// range and drives the response register. Depends on afbu_pkg.
module afbu_accum (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  afbu_pkg::afbu_s3_t s3_i,
  output logic               done_o,
  output afbu_pkg::act_rsp_t rsp_o
);

  localparam int RW = afbu_pkg::PROD_W;
  localparam int SW = afbu_pkg::SUM_W;

  logic signed [RW-1:0] term;
  logic signed [SW-1:0] sum;
  logic                 done_q;
  afbu_pkg::act_rsp_t   rsp_d, rsp_q;

  always_comb begin
    if (s3_i.op == afbu_pkg::OP_BWD_SIG || s3_i.op == afbu_pkg::OP_BWD_TANH) begin
      term = s3_i.m2 >>> afbu_pkg::FRAC_BITS;
    end else begin
      term = s3_i.addend;
    end
    sum   = SW'(s3_i.base) + SW'(term);
    rsp_d = afbu_pkg::sat_clamp(sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// File: sv/activation_forward_backward_unit.sv
// Top level of the element-wise activation unit: configuration registers,
// entry register and the four compute stages. Depends on afbu_pkg and the
// afbu_front, afbu_deriv, afbu_mul2 and afbu_accum stage modules.
//
// Usage: a request (x_value, y_value, upstream_grad, grad_sum in signed Q4.12)
// is taken at a rising edge where start is high and busy is low. busy is
// held low at all times, so one request may be issued on every cycle.
// Each request yields exactly one response (result_value, saturated) that is
// shown on rsp_o for a single cycle while done_o is high; the receiver must
// take it then, as the unit has no means to hold it.
// Path: the response is registered in the sum and clamp register after the
// request has passed the entry register, first multiplier, derivative and
// second multiplier registers, in that order.
// Throughput is one request per cycle; the two multipliers set the stage
// boundaries.
// Configuration: cfg_we_i writes cfg_wdata_i into the register chosen by
// cfg_addr_i (0 kind, 1 pass direction, 2 negative slope) on the same edge.
// Change it only while no request is in flight; each request samples the
// configuration as it enters. Reset clears the pipeline valid bits and
// returns the registers to leaky ReLU, forward pass and a slope of 41.
module activation_forward_backward_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  afbu_pkg::act_req_t                   req_i,
  output logic                                 done_o,
  output afbu_pkg::act_rsp_t                   rsp_o,
  input  logic                                 cfg_we_i,
  input  logic [afbu_pkg::CFG_ADDR_WIDTH-1:0]  cfg_addr_i,
  input  logic [afbu_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata_i
);

  // Configuration registers. The kind is kept as raw bits because the unused
  // code must still be held; it decodes as leaky ReLU.
  logic [afbu_pkg::KIND_WIDTH-1:0]  kind_q;
  afbu_pkg::act_pass_e              dir_q;
  logic [afbu_pkg::SLOPE_WIDTH-1:0] slope_q;

  // Entry register and the valid bits between the stages.
  logic               accept;
  logic               v0_q;
  afbu_pkg::afbu_s0_t s0_d, s0_q;
  logic               v1, v2, v3;
  afbu_pkg::afbu_s1_t s1;
  afbu_pkg::afbu_s2_t s2;
  afbu_pkg::afbu_s3_t s3;
  afbu_pkg::act_op_e  op;

  // The pipeline never stalls, so the unit is never busy.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= afbu_pkg::KIND_LEAKY;
      dir_q   <= afbu_pkg::PASS_FORWARD;
      slope_q <= afbu_pkg::SLOPE_WIDTH'(afbu_pkg::SLOPE_RESET);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        afbu_pkg::REG_KIND: begin
          kind_q <= cfg_wdata_i[afbu_pkg::KIND_WIDTH-1:0];
        end
        afbu_pkg::REG_DIR: begin
          dir_q <= afbu_pkg::act_pass_e'(cfg_wdata_i[0]);
        end
        afbu_pkg::REG_SLOPE: begin
          slope_q <= cfg_wdata_i[afbu_pkg::SLOPE_WIDTH-1:0];
        end
        default: begin
          // Writes beyond the register list are ignored.
        end
      endcase
    end
  end

  // Decode the function and pass into one operation code for the pipeline.
  always_comb begin
    if (dir_q == afbu_pkg::PASS_BACKWARD) begin
      unique case (kind_q)
        afbu_pkg::KIND_SIGMOID: op = afbu_pkg::OP_BWD_SIG;
        afbu_pkg::KIND_TANH:    op = afbu_pkg::OP_BWD_TANH;
        default:                op = afbu_pkg::OP_BWD_LEAKY;
      endcase
    end else begin
      unique case (kind_q)
        afbu_pkg::KIND_SIGMOID: op = afbu_pkg::OP_FWD_SIG;
        afbu_pkg::KIND_TANH:    op = afbu_pkg::OP_FWD_TANH;
        default:                op = afbu_pkg::OP_FWD_LEAKY;
      endcase
    end
    s0_d.op    = op;
    s0_d.req   = req_i;
    s0_d.slope = slope_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s0_q <= s0_d;
    end
  end

  // Stage one: first multiplier and the piecewise-linear curve.
  afbu_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v0_q),
    .s0_i    (s0_q),
    .valid_o (v1),
    .s1_o    (s1)
  );

  // Stage two: product scaling and the clamped local derivative.
  afbu_deriv u_deriv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1),
    .s1_i    (s1),
    .valid_o (v2),
    .s2_o    (s2)
  );

  // Stage three: gradient times derivative.
  afbu_mul2 u_mul2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2),
    .s2_i    (s2),
    .valid_o (v3),
    .s3_o    (s3)
  );

  // Stage four: accumulate, saturate and present the response.
  afbu_accum u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3),
    .s3_i    (s3),
    .done_o  (done_o),
    .rsp_o   (rsp_o)
  );

endmodule
